/* src/serial_speech_rom_interface_top_macros.svh */
// assertion macros for the serial speech rom interface
// clocked on aclk, disabled while aresetn is low
`ifndef SERIAL_SPEECH_ROM_INTERFACE_TOP_MACROS_SVH
`define SERIAL_SPEECH_ROM_INTERFACE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSRI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SSRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSRI_ASSERT_SAME(lbl, ante, cons, msg)
`define SSRI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/ssri_pkg.sv */
`timescale 1ns / 1ps
// beat types and mode codes for the serial speech rom interface
// no dependencies
package ssri_pkg;

    localparam int BRANCH_BITS   = 14;
    localparam int OUT_ADDR_BITS = 17;
    localparam int LOAD_ADDR_BITS = 14;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_READ      = 2'd1,
        MODE_LOAD_ADDR = 2'd2,
        MODE_BRANCH    = 2'd3
    } mode_t;

    typedef struct packed {
        logic                      kind;
        logic [1:0]                mode;
        logic [3:0]                addr_nibble;
        logic [LOAD_ADDR_BITS-1:0] rom_address;
        logic [7:0]                rom_byte;
    } in_beat_t;

    typedef struct packed {
        logic                     data_bit;
        logic [OUT_ADDR_BITS-1:0] bit_address;
    } out_beat_t;

endpackage

/* src/ssri_rom.sv */
`timescale 1ns / 1ps
// byte-wide rom store, one write port and two registered read ports
// no dependencies
module ssri_rom #(
    parameter int ROM_ADDR_BITS = 14
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ROM_ADDR_BITS-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic [ROM_ADDR_BITS-1:0] rd_addr_a,
    input  logic [ROM_ADDR_BITS-1:0] rd_addr_b,
    output logic [7:0]               rd_data_a,
    output logic [7:0]               rd_data_b
);

    localparam int DEPTH = 1 << ROM_ADDR_BITS;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_a_reg;
    logic [7:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* src/ssri_exec.sv */
`timescale 1ns / 1ps
// pointer, address latch and read flags, updated once per clock-edge beat
// uses ssri_pkg; rom read addresses come from the forwarded next state
module ssri_exec #(
    parameter int ROM_ADDR_BITS = 14,
    parameter int LATCH_NIBBLES = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     exec_en,
    input  ssri_pkg::in_beat_t       item,
    input  logic [7:0]               rd_data_a,
    input  logic [7:0]               rd_data_b,
    output logic [ROM_ADDR_BITS-1:0] rd_addr_a,
    output logic [ROM_ADDR_BITS-1:0] rd_addr_b,
    output ssri_pkg::out_beat_t      result
);

    localparam int PW = ROM_ADDR_BITS + 3;
    localparam int LW = 4 * LATCH_NIBBLES;
    localparam int CW = $clog2(LATCH_NIBBLES + 1);

    logic [PW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] latch_reg, latch_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          read_pend_reg, read_pend_next;
    logic          dummy_pend_reg, dummy_pend_next;
    logic          dout_reg, dout_next;

    always_comb begin
        ssri_pkg::mode_t      mode;
        logic [ROM_ADDR_BITS-1:0] target;
        mode            = ssri_pkg::mode_t'(item.mode);
        target          = ROM_ADDR_BITS'({rd_data_b[5:0], rd_data_a});
        ptr_next        = ptr_reg;
        latch_next      = latch_reg;
        cnt_next        = cnt_reg;
        read_pend_next  = read_pend_reg;
        dummy_pend_next = dummy_pend_reg;
        dout_next       = dout_reg;
        if (exec_en) begin
            case (mode)
                ssri_pkg::MODE_IDLE: begin
                    if (read_pend_reg) begin
                        if (dummy_pend_reg) begin
                            ptr_next        = {ROM_ADDR_BITS'(latch_reg), 3'b000};
                            latch_next      = '0;
                            cnt_next        = '0;
                            dummy_pend_next = 1'b0;
                        end else begin
                            dout_next = rd_data_a[~ptr_reg[2:0]];
                            ptr_next  = ptr_reg + PW'(1);
                        end
                        read_pend_next = 1'b0;
                    end
                end
                ssri_pkg::MODE_READ: begin
                    read_pend_next = 1'b1;
                end
                ssri_pkg::MODE_LOAD_ADDR: begin
                    dummy_pend_next = 1'b1;
                    if (cnt_reg < CW'(LATCH_NIBBLES)) begin
                        for (int i = 0; i < LATCH_NIBBLES; i++) begin
                            if (cnt_reg == CW'(i)) begin
                                latch_next[4*i +: 4] = latch_reg[4*i +: 4] | item.addr_nibble;
                            end
                        end
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                ssri_pkg::MODE_BRANCH: begin
                    if (dummy_pend_reg) begin
                        ptr_next        = {target, 3'b000};
                        latch_next      = '0;
                        cnt_next        = '0;
                        dummy_pend_next = 1'b0;
                    end
                end
                default: begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
    end

    // reads for the following beat, forwarded from this beat's update
    assign rd_addr_a = dummy_pend_next ? ROM_ADDR_BITS'(latch_next) : ptr_next[PW-1:3];
    assign rd_addr_b = ROM_ADDR_BITS'(latch_next) + ROM_ADDR_BITS'(1);

    assign result.data_bit    = dout_next;
    assign result.bit_address = ssri_pkg::OUT_ADDR_BITS'(ptr_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            latch_reg      <= '0;
            cnt_reg        <= '0;
            read_pend_reg  <= 1'b0;
            dummy_pend_reg <= 1'b0;
            dout_reg       <= 1'b0;
        end else begin
            ptr_reg        <= ptr_next;
            latch_reg      <= latch_next;
            cnt_reg        <= cnt_next;
            read_pend_reg  <= read_pend_next;
            dummy_pend_reg <= dummy_pend_next;
            dout_reg       <= dout_next;
        end
    end

endmodule

/* src/serial_speech_rom_interface_top.sv */
`timescale 1ns / 1ps
// serial speech rom interface, top level
// uses ssri_pkg, ssri_rom, ssri_exec and the assertion macro header
//
//   channel | direction | payload              | beat
//   s_      | in        | ssri_pkg::in_beat_t  | rom load or one falling clock edge
//   m_      | out       | ssri_pkg::out_beat_t | data bit and bit pointer per clock edge
//
// one beat per cycle sustained while no result stalls; each clock-edge beat waits in the execute
// register, reading its rom bytes in the cycle of its acceptance from the forwarded state
// load beats write the rom on acceptance and give no result
// reset is synchronous and clears pointer, latch and flags; rom contents are kept;
// no beat is taken while aresetn is low
// a stalled result holds the execute register, which then holds its rom read address
module serial_speech_rom_interface_top #(
    parameter int ROM_ADDR_BITS = 14,
    parameter int LATCH_NIBBLES = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssri_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssri_pkg::out_beat_t m_data
);

    logic                     b_valid_reg, b_valid_next;
    ssri_pkg::in_beat_t       b_item_reg;
    logic                     m_valid_reg, m_valid_next;
    ssri_pkg::out_beat_t      m_data_reg;
    logic                     b_fire;
    logic                     accept;
    logic                     load_we;
    logic                     edge_in;
    logic [ROM_ADDR_BITS-1:0] rd_addr_a, rd_addr_b;
    logic [7:0]               rd_data_a, rd_data_b;
    ssri_pkg::out_beat_t      result;

    assign b_fire  = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = aresetn && (!b_valid_reg || b_fire);
    assign accept  = s_valid && s_ready;
    assign load_we = accept && (s_data.kind == ssri_pkg::KIND_LOAD);
    assign edge_in = accept && (s_data.kind == ssri_pkg::KIND_EDGE);

    assign b_valid_next = edge_in ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);
    assign m_valid_next = b_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    ssri_rom #(
        .ROM_ADDR_BITS(ROM_ADDR_BITS)
    ) u_rom (
        .aclk      (aclk),
        .wr_en     (load_we),
        .wr_addr   (ROM_ADDR_BITS'(s_data.rom_address)),
        .wr_data   (s_data.rom_byte),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    ssri_exec #(
        .ROM_ADDR_BITS(ROM_ADDR_BITS),
        .LATCH_NIBBLES(LATCH_NIBBLES)
    ) u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .exec_en   (b_fire),
        .item      (b_item_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (edge_in) begin
            b_item_reg <= s_data;
        end
        if (b_fire) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "serial_speech_rom_interface_top_macros.svh"

    `SSRI_ASSERT_SAME(a_no_load_under_stall, load_we, !(b_valid_reg && !b_fire), "rom write while beat stalled")
    `SSRI_ASSERT_NEXT(a_result_loaded, b_fire, m_valid_reg, "executed beat gave no result")
    `SSRI_ASSERT_NEXT(a_stall_holds_reads, b_valid_reg && !b_fire, b_fire || ($stable(rd_addr_a) && $stable(rd_addr_b)), "rom read address moved under stall")
    `SSRI_ASSERT_NEXT(a_edge_enters_exec, edge_in, b_valid_reg, "accepted clock beat lost")

endmodule
